// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the command framer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GCF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gcf_pkg.sv =====
// ---------------------------------------------------------------------------
// gcf_pkg
// Types and constants shared by the gimbal command framer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package gcf_pkg;

   localparam int BYTE_W    = 8;
   localparam int ANGLE_W   = 28;
   localparam int SPEED_W   = 16;
   localparam int TIME_W    = 32;
   localparam int MAG_W     = 28;
   localparam int PROD_W    = MAG_W + BYTE_W;     // magnitude times scale
   localparam int DIVD_W    = PROD_W - 2;         // product divided by four
   localparam int RECIP_W   = 30;
   localparam int QUOT_W    = 30;
   localparam int PART_LO_W = 17;
   localparam int PART_HI_W = DIVD_W - PART_LO_W;
   localparam int PART_W    = PART_LO_W + RECIP_W;
   localparam int SUM_W     = PART_W + PART_LO_W;
   localparam int FRAME_MAX = 9;
   localparam int LEN_W     = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'h7A;
   localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'h7B;
   localparam logic [BYTE_W-1:0] FN_SPEED   = 8'h01;
   localparam logic [BYTE_W-1:0] FN_MULTI   = 8'h02;
   localparam logic [BYTE_W-1:0] FN_SINGLE  = 8'h03;

   localparam logic MODE_TARGET = 1'b0;
   localparam logic MODE_POLL   = 1'b1;

   // 359.9 degrees and 0.05 degree, in hundredths of a degree.
   localparam logic signed [ANGLE_W-1:0] PITCH_MAX_CD = 28'sd35990;
   localparam logic signed [ANGLE_W:0]   DEADBAND_CD  = 29'sd5;
   localparam logic signed [ANGLE_W:0]   NEG_DEADBAND = -29'sd5;

   // floor(2^34 / 25): dividing by 100 is a shift by two and a divide by 25.
   localparam logic [RECIP_W-1:0] RECIP_25   = 30'd687194767;
   localparam int                 RECIP_SHFT = 34;
   localparam logic [QUOT_W-1:0]  PITCH_SAT  = 30'd65535;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_YAW_ID        = 2'd0,
      CSR_PITCH_ID      = 2'd1,
      CSR_ANGLE_SCALE   = 2'd2,
      CSR_SEND_INTERVAL = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] yaw_id;
      logic [BYTE_W-1:0] pitch_id;
      logic [BYTE_W-1:0] angle_scale;
      logic [BYTE_W-1:0] send_interval;
   } cfg_type;

   typedef enum logic [1:0] {
      DESC_SPEED = 2'd0,
      DESC_YAW   = 2'd1,
      DESC_PITCH = 2'd2
   } desc_kind_type;

   // One frame to send, as decided by the front end.
   typedef struct packed {
      desc_kind_type      kind;
      logic [BYTE_W-1:0]  id;
      logic               neg;
      logic [MAG_W-1:0]   mag;
      logic [SPEED_W-1:0] speed;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

`default_nettype wire

// ===== hdl/gcf_if.sv =====
// ---------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for target and poll words in and frame bytes out.
// ---------------------------------------------------------------------------
`default_nettype none

interface gcf_req_if;
   import gcf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic signed [ANGLE_W-1:0] yaw_angle;
   logic signed [ANGLE_W-1:0] pitch_angle;
   logic signed [SPEED_W-1:0] speed;
   logic [TIME_W-1:0]         now_ms;

   modport source (output valid, mode, yaw_angle, pitch_angle, speed, now_ms,
                   input ready);
   modport sink (input valid, mode, yaw_angle, pitch_angle, speed, now_ms,
                 output ready);
endinterface

interface gcf_rsp_if;
   import gcf_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] tx_byte;
   logic              frame_end;

   modport source (output valid, tx_byte, frame_end, input ready);
   modport sink (input valid, tx_byte, frame_end, output ready);
endinterface

`default_nettype wire

// ===== hdl/gcf_front.sv =====
// ---------------------------------------------------------------------------
// gcf_front
// Accepts target and poll words, keeps the per-motor schedule and pushes
// one frame descriptor for each frame that a poll decides to send.
// ---------------------------------------------------------------------------
`default_nettype none

module gcf_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   gcf_req_if.sink                      req,
   input  wire gcf_pkg::cfg_type        cfg,
   input  wire gcf_pkg::queue_stat_type q_stat,
   output logic                         push,
   output gcf_pkg::desc_type            push_desc
);
   import gcf_pkg::*;

   typedef enum logic [1:0] {
      PH_SPEED = 2'd0,
      PH_ANGLE = 2'd1,
      PH_DONE  = 2'd2
   } phase_type;

   logic [TIME_W-1:0]         last_send_ff, last_send_in;
   logic                      serve_pitch_ff, serve_pitch_in;
   logic                      pending_ff [2];
   logic                      pending_in [2];
   logic [1:0]                phase_ff [2];
   logic [1:0]                phase_in [2];
   logic signed [SPEED_W-1:0] goal_speed_ff [2];
   logic signed [SPEED_W-1:0] goal_speed_in [2];
   logic signed [SPEED_W-1:0] sent_speed_ff [2];
   logic signed [SPEED_W-1:0] sent_speed_in [2];
   logic signed [ANGLE_W-1:0] goal_angle_ff [2];
   logic signed [ANGLE_W-1:0] goal_angle_in [2];
   logic signed [ANGLE_W-1:0] sent_angle_ff [2];
   logic signed [ANGLE_W-1:0] sent_angle_in [2];

   logic                      accept;
   logic                      m;
   logic [TIME_W-1:0]         elapsed;
   logic                      interval_ok;
   logic signed [ANGLE_W-1:0] goal_cd;
   logic [ANGLE_W-1:0]        goal_bits;
   logic signed [ANGLE_W:0]   angle_diff;
   logic                      angle_moved;
   logic [MAG_W-1:0]          yaw_mag;
   logic [MAG_W-1:0]          pitch_mag;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign m         = serve_pitch_ff;

   always_comb begin
      elapsed     = req.now_ms - last_send_ff;
      interval_ok = elapsed >= TIME_W'(cfg.send_interval);
      goal_cd     = goal_angle_ff[m];
      goal_bits   = goal_cd;
      angle_diff  = {goal_cd[ANGLE_W-1], goal_cd}
                    - {sent_angle_ff[m][ANGLE_W-1], sent_angle_ff[m]};
      angle_moved = (angle_diff >= DEADBAND_CD) || (angle_diff <= NEG_DEADBAND);
      yaw_mag     = goal_bits[ANGLE_W-1] ? (MAG_W'(0) - goal_bits) : goal_bits;
      if (goal_cd < 0) begin
         pitch_mag = '0;
      end else if (goal_cd > PITCH_MAX_CD) begin
         pitch_mag = PITCH_MAX_CD;
      end else begin
         pitch_mag = goal_bits;
      end
   end

   always_comb begin
      last_send_in   = last_send_ff;
      serve_pitch_in = serve_pitch_ff;
      pending_in     = pending_ff;
      phase_in       = phase_ff;
      goal_speed_in  = goal_speed_ff;
      sent_speed_in  = sent_speed_ff;
      goal_angle_in  = goal_angle_ff;
      sent_angle_in  = sent_angle_ff;

      push            = 1'b0;
      push_desc.kind  = DESC_SPEED;
      push_desc.id    = m ? cfg.pitch_id : cfg.yaw_id;
      push_desc.neg   = 1'b0;
      push_desc.mag   = m ? pitch_mag : yaw_mag;
      push_desc.speed = goal_speed_ff[m];

      if (accept) begin
         if (req.mode == MODE_TARGET) begin
            goal_angle_in[0] = req.yaw_angle;
            goal_angle_in[1] = req.pitch_angle;
            goal_speed_in[0] = req.speed;
            goal_speed_in[1] = req.speed;
            pending_in[0]    = 1'b1;
            pending_in[1]    = 1'b1;
         end else if (interval_ok) begin
            // The turn passes to the other motor even when this one is idle.
            serve_pitch_in = !serve_pitch_ff;
            if (pending_ff[m]) begin
               last_send_in = req.now_ms;
               unique case (phase_type'(phase_ff[m]))
                  PH_SPEED: begin
                     phase_in[m] = PH_ANGLE;
                     if (goal_speed_ff[m] != sent_speed_ff[m]) begin
                        sent_speed_in[m] = goal_speed_ff[m];
                        push             = 1'b1;
                     end
                  end
                  PH_ANGLE: begin
                     phase_in[m] = PH_DONE;
                     if (angle_moved) begin
                        sent_angle_in[m] = goal_cd;
                        push             = 1'b1;
                        push_desc.kind   = m ? DESC_PITCH : DESC_YAW;
                        push_desc.neg    = m ? 1'b0 : goal_bits[ANGLE_W-1];
                     end
                  end
                  default: begin
                     pending_in[m] = 1'b0;
                     phase_in[m]   = PH_SPEED;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_send_ff   <= '0;
         serve_pitch_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            pending_ff[i]    <= 1'b0;
            phase_ff[i]      <= PH_SPEED;
            goal_speed_ff[i] <= '0;
            sent_speed_ff[i] <= '0;
            goal_angle_ff[i] <= '0;
            sent_angle_ff[i] <= '0;
         end
      end else begin
         last_send_ff   <= last_send_in;
         serve_pitch_ff <= serve_pitch_in;
         pending_ff     <= pending_in;
         phase_ff       <= phase_in;
         goal_speed_ff  <= goal_speed_in;
         sent_speed_ff  <= sent_speed_in;
         goal_angle_ff  <= goal_angle_in;
         sent_angle_ff  <= sent_angle_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/gcf_queue.sv =====
// ---------------------------------------------------------------------------
// gcf_queue
// Small first-in first-out buffer of frame descriptors between the front
// and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module gcf_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire gcf_pkg::desc_type       push_desc,
   input  wire logic                    pop,
   output gcf_pkg::desc_type            pop_desc,
   output gcf_pkg::queue_stat_type      stat
);
   import gcf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_desc   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_desc;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/gcf_back.sv =====
// ---------------------------------------------------------------------------
// gcf_back
// Takes frame descriptors from the queue, scales angles to motor units,
// assembles the frame with its check byte and sends it one byte per word.
// ---------------------------------------------------------------------------
`default_nettype none

module gcf_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [gcf_pkg::BYTE_W-1:0] angle_scale,
   input  wire gcf_pkg::queue_stat_type q_stat,
   input  wire gcf_pkg::desc_type       pop_desc,
   output logic                         pop,
   gcf_rsp_if.source                    rsp
);
   import gcf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_MUL   = 3'd1,
      ST_RECIP = 3'd2,
      ST_EST   = 3'd3,
      ST_FIX   = 3'd4,
      ST_BUILD = 3'd5,
      ST_SEND  = 3'd6
   } state_type;

   state_type          state_ff, state_in;
   desc_type           desc_ff, desc_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIVD_W-1:0]  divd_ff, divd_in;
   logic [PART_W-1:0]  part_hi_ff, part_hi_in;
   logic [PART_W-1:0]  part_lo_ff, part_lo_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [BYTE_W-1:0]  frame_ff [FRAME_MAX];
   logic [BYTE_W-1:0]  frame_in [FRAME_MAX];
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_end_ff, rsp_end_in;

   logic               slot_free;
   logic [SUM_W-1:0]   est_sum;
   logic [DIVD_W:0]    quot_x25;
   logic [DIVD_W:0]    rem;
   logic [TIME_W-1:0]  yaw_value;
   logic [SPEED_W-1:0] short_value;
   logic [BYTE_W-1:0]  fn_code;
   logic [BYTE_W-1:0]  check;

   assign slot_free     = !rsp_valid_ff || rsp.ready;
   assign pop           = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.tx_byte   = rsp_byte_ff;
   assign rsp.frame_end = rsp_end_ff;

   // Scaling datapath: |cd| * scale / 100 as (product >> 2) / 25 through a
   // truncated reciprocal, which lands on the quotient or one below it.
   always_comb begin
      prod_in    = PROD_W'(desc_ff.mag) * PROD_W'(angle_scale);
      divd_in    = prod_ff[PROD_W-1:2];
      part_hi_in = PART_W'(divd_in[DIVD_W-1:PART_LO_W]) * PART_W'(RECIP_25);
      part_lo_in = PART_W'(divd_in[PART_LO_W-1:0]) * PART_W'(RECIP_25);
      est_sum    = {part_hi_ff, {PART_LO_W{1'b0}}} + SUM_W'(part_lo_ff);
      quot_x25   = ((DIVD_W + 1)'(quot_ff) << 4) + ((DIVD_W + 1)'(quot_ff) << 3)
                   + (DIVD_W + 1)'(quot_ff);
      rem        = (DIVD_W + 1)'(divd_ff) - quot_x25;
      yaw_value  = desc_ff.neg ? (TIME_W'(0) - TIME_W'(quot_ff)) : TIME_W'(quot_ff);
      if (desc_ff.kind == DESC_SPEED) begin
         short_value = desc_ff.speed;
      end else if (quot_ff > PITCH_SAT) begin
         short_value = '1;
      end else begin
         short_value = quot_ff[SPEED_W-1:0];
      end
   end

   always_comb begin
      unique case (desc_ff.kind)
         DESC_YAW:   fn_code = FN_MULTI;
         DESC_PITCH: fn_code = FN_SINGLE;
         default:    fn_code = FN_SPEED;
      endcase
      if (desc_ff.kind == DESC_YAW) begin
         check = FRAME_HEAD ^ desc_ff.id ^ fn_code ^ yaw_value[31:24]
                 ^ yaw_value[23:16] ^ yaw_value[15:8] ^ yaw_value[7:0];
      end else begin
         check = FRAME_HEAD ^ desc_ff.id ^ fn_code ^ short_value[15:8]
                 ^ short_value[7:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      quot_in      = quot_ff;
      frame_in     = frame_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;

      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               desc_in  = pop_desc;
               state_in = (pop_desc.kind == DESC_SPEED) ? ST_BUILD : ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            state_in = ST_EST;
         end
         ST_EST: begin
            quot_in  = est_sum[SUM_W-1:RECIP_SHFT];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (rem >= (DIVD_W + 1)'(25)) begin
               quot_in = quot_ff + 1'b1;
            end
            state_in = ST_BUILD;
         end
         ST_BUILD: begin
            frame_in[0] = FRAME_HEAD;
            frame_in[1] = desc_ff.id;
            frame_in[2] = fn_code;
            if (desc_ff.kind == DESC_YAW) begin
               frame_in[3] = yaw_value[31:24];
               frame_in[4] = yaw_value[23:16];
               frame_in[5] = yaw_value[15:8];
               frame_in[6] = yaw_value[7:0];
               frame_in[7] = check;
               frame_in[8] = FRAME_TAIL;
               remain_in   = LEN_W'(9);
            end else begin
               frame_in[3] = short_value[15:8];
               frame_in[4] = short_value[7:0];
               frame_in[5] = check;
               frame_in[6] = FRAME_TAIL;
               frame_in[7] = '0;
               frame_in[8] = '0;
               remain_in   = LEN_W'(7);
            end
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = frame_ff[0];
               rsp_end_in   = (remain_ff == LEN_W'(1));
               for (int i = 0; i < FRAME_MAX - 1; i++) begin
                  frame_in[i] = frame_ff[i + 1];
               end
               frame_in[FRAME_MAX-1] = '0;
               remain_in = remain_ff - 1'b1;
               if (remain_ff == LEN_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      prod_ff     <= prod_in;
      divd_ff     <= divd_in;
      part_hi_ff  <= part_hi_in;
      part_lo_ff  <= part_lo_in;
      quot_ff     <= quot_in;
      frame_ff    <= frame_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/gimbal_command_framer_unit.sv =====
// ---------------------------------------------------------------------------
// gimbal_command_framer_unit
// Two-motor command scheduler and serial framer: target and poll words in,
// command frame bytes out.
// ---------------------------------------------------------------------------
//  channel   dir  handshake      word
//  req_chan  in   valid/ready    mode, yaw/pitch angle, speed, time
//  rsp_chan  out  valid/ready    one frame byte, frame_end on the tail
//  csr_*     in   write enable   register index and 8-bit data
//
// The front end takes a word every cycle while the descriptor queue has room.
// The back end takes the descriptor, runs the scaling multiply and divide by 100
// on angle frames through the MUL, RECIP, EST and FIX states, assembles the frame
// and then sends it one byte per word.
// Reset is synchronous and clears schedule state, queue and output register.
// Either side may stall; the output register holds a word until it is taken.
`default_nettype none

`include "assert_macros.svh"

module gimbal_command_framer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   gcf_req_if.sink                            req_chan,
   gcf_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [gcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gcf_pkg::BYTE_W-1:0]    csr_wr_data
);
   import gcf_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   queue_stat_type q_stat;
   desc_type       push_desc;
   desc_type       pop_desc;
   logic           q_push;
   logic           q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_YAW_ID:        cfg_in.yaw_id        = csr_wr_data;
            CSR_PITCH_ID:      cfg_in.pitch_id      = csr_wr_data;
            CSR_ANGLE_SCALE:   cfg_in.angle_scale   = csr_wr_data;
            CSR_SEND_INTERVAL: cfg_in.send_interval = csr_wr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_id        <= 8'd1;
         cfg_ff.pitch_id      <= 8'd2;
         cfg_ff.angle_scale   <= 8'd10;
         cfg_ff.send_interval <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_desc (push_desc)
   );

   gcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .pop_desc  (pop_desc),
      .stat      (q_stat)
   );

   gcf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .angle_scale (cfg_ff.angle_scale),
      .q_stat      (q_stat),
      .pop_desc    (pop_desc),
      .pop         (q_pop),
      .rsp         (rsp_chan)
   );

   `GCF_ASSERT_IMPLIES(a_no_push_full, clock, reset, q_push, !q_stat.full, "push into full queue")
   `GCF_ASSERT_IMPLIES(a_no_pop_empty, clock, reset, q_pop, !q_stat.empty, "pop from empty queue")
   `GCF_ASSERT_IMPLIES(a_end_is_tail, clock, reset, rsp_chan.valid && rsp_chan.frame_end, rsp_chan.tx_byte == FRAME_TAIL, "frame end word is not the tail byte")
   `GCF_ASSERT_NEXT(a_head_after_tail, clock, reset, rsp_chan.valid && rsp_chan.ready && rsp_chan.frame_end, !rsp_chan.valid || (rsp_chan.tx_byte == FRAME_HEAD), "word after a tail is not a head byte")

endmodule

`default_nettype wire

// ===== sim/gcf_frame_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gcf_frame_checker
// Watches the word channels and the register port of the command framer,
// schedules both motors the same way the block must, builds the expected
// frame bytes and compares every byte that leaves the block against them.
// ---------------------------------------------------------------------------
module gcf_frame_checker (
   input  logic                          clock,
   input  logic                          reset,
   gcf_req_if                            req_mon,
   gcf_rsp_if                            rsp_mon,
   input  logic                          csr_wr_en,
   input  logic [gcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gcf_pkg::BYTE_W-1:0]    csr_wr_data,
   output int                            fail_count,
   output int                            words_due
);
   import gcf_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_word_type;

   frame_word_type bytes_due [$];
   int             mismatches = 0;

   cfg_type                   cfg;
   logic [TIME_W-1:0]         last_send_ms;
   logic                      serve_pitch;
   logic                      pending   [2];
   logic [1:0]                phase     [2];
   logic signed [SPEED_W-1:0] goal_spd  [2];
   logic signed [SPEED_W-1:0] sent_spd  [2];
   logic signed [ANGLE_W-1:0] goal_cd   [2];
   logic signed [ANGLE_W-1:0] sent_cd   [2];

   // Header, address, function, big-endian data, XOR check and tail.
   task automatic push_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] fn,
                             input logic [31:0] value, input int len);
      logic [BYTE_W-1:0] frame [$];
      logic [BYTE_W-1:0] chk;
      frame = {FRAME_HEAD, id, fn};
      for (int i = len - 1; i >= 0; i--) frame.push_back(value[8*i +: 8]);
      chk = '0;
      foreach (frame[i]) chk ^= frame[i];
      frame.push_back(chk);
      frame.push_back(FRAME_TAIL);
      foreach (frame[i]) bytes_due.push_back('{data: frame[i], last: (i == frame.size() - 1)});
   endtask

   always @(posedge clock) begin : track
      int                m;
      logic [TIME_W-1:0] elapsed;
      logic [BYTE_W-1:0] id;
      longint            diff;
      longint            cd;
      longint            scaled;
      frame_word_type    want;
      if (reset) begin
         cfg = '{yaw_id: 8'd1, pitch_id: 8'd2, angle_scale: 8'd10, send_interval: 8'd1};
         last_send_ms = '0;
         serve_pitch = 1'b0;
         for (int i = 0; i < 2; i++) begin
            pending[i]  = 1'b0;
            phase[i]    = 2'd0;
            goal_spd[i] = '0;
            sent_spd[i] = '0;
            goal_cd[i]  = '0;
            sent_cd[i]  = '0;
         end
         bytes_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_YAW_ID:        cfg.yaw_id        = csr_wr_data;
               CSR_PITCH_ID:      cfg.pitch_id      = csr_wr_data;
               CSR_ANGLE_SCALE:   cfg.angle_scale   = csr_wr_data;
               CSR_SEND_INTERVAL: cfg.send_interval = csr_wr_data;
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.mode == MODE_TARGET) begin
               // New targets keep whatever phase each motor is in.
               goal_cd[0]  = req_mon.yaw_angle;
               goal_cd[1]  = req_mon.pitch_angle;
               goal_spd[0] = req_mon.speed;
               goal_spd[1] = req_mon.speed;
               pending[0]  = 1'b1;
               pending[1]  = 1'b1;
            end else begin
               elapsed = req_mon.now_ms - last_send_ms;
               if (elapsed >= TIME_W'(cfg.send_interval)) begin
                  // The turn passes to the other motor even when this one is idle.
                  m = serve_pitch ? 1 : 0;
                  serve_pitch = !serve_pitch;
                  if (pending[m]) begin
                     last_send_ms = req_mon.now_ms;
                     id = (m == 0) ? cfg.yaw_id : cfg.pitch_id;
                     case (phase[m])
                        2'd0: begin
                           phase[m] = 2'd1;
                           if (goal_spd[m] != sent_spd[m]) begin
                              sent_spd[m] = goal_spd[m];
                              push_frame(id, FN_SPEED, {16'h0, goal_spd[m]}, 2);
                           end
                        end
                        2'd1: begin
                           phase[m] = 2'd2;
                           diff = longint'(goal_cd[m]) - longint'(sent_cd[m]);
                           if (diff < 0) diff = -diff;
                           if (diff >= longint'(DEADBAND_CD)) begin
                              sent_cd[m] = goal_cd[m];
                              cd = longint'(goal_cd[m]);
                              if (m == 0) begin
                                 scaled = (cd * longint'(cfg.angle_scale)) / 100;
                                 push_frame(id, FN_MULTI, scaled[31:0], 4);
                              end else begin
                                 if (cd < 0) cd = 0;
                                 if (cd > longint'(PITCH_MAX_CD)) cd = longint'(PITCH_MAX_CD);
                                 scaled = (cd * longint'(cfg.angle_scale)) / 100;
                                 if (scaled > longint'(PITCH_SAT)) scaled = longint'(PITCH_SAT);
                                 push_frame(id, FN_SINGLE, scaled[31:0], 2);
                              end
                           end
                        end
                        default: begin
                           pending[m] = 1'b0;
                           phase[m]   = 2'd0;
                        end
                     endcase
                  end
               end
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (bytes_due.size() == 0) begin
               $error("tx_byte %02h arrived while no frame byte was expected",
                      rsp_mon.tx_byte);
               mismatches++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_mon.tx_byte !== want.data) begin
                  $error("tx_byte: expected %02h, got %02h", want.data, rsp_mon.tx_byte);
                  mismatches++;
               end
               if (rsp_mon.frame_end !== want.last) begin
                  $error("frame_end: expected %0b, got %0b", want.last, rsp_mon.frame_end);
                  mismatches++;
               end
            end
         end
      end
      fail_count <= mismatches;
      words_due  <= bytes_due.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives target and poll words into the gimbal command framer under random
// stalls on both channels, steps the registers through several settings
// between phases, and reports the verdict from the frame checker.
// ---------------------------------------------------------------------------
module tb;
   import gcf_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_GAP       = 18;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wr_data;
   int                   fail_count;
   int                   words_due;

   bit                        calm = 1'b0;
   bit                        hold_rsp = 1'b0;
   logic [TIME_W-1:0]         sim_ms = '0;
   logic [BYTE_W-1:0]         cur_interval = 8'd1;
   logic signed [ANGLE_W-1:0] last_yaw = '0;
   logic signed [ANGLE_W-1:0] last_pitch = '0;
   logic signed [SPEED_W-1:0] last_speed = '0;

   gcf_req_if req_chan ();
   gcf_rsp_if rsp_chan ();

   gimbal_command_framer_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   gcf_frame_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .words_due   (words_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: a random stall before each word, and one long hold-off on request.
   initial begin : receiver
      int stall;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   task automatic send_word(input logic mode, input logic signed [ANGLE_W-1:0] yaw,
                            input logic signed [ANGLE_W-1:0] pitch,
                            input logic signed [SPEED_W-1:0] speed,
                            input logic [TIME_W-1:0] now);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= mode;
      req_chan.yaw_angle   <= yaw;
      req_chan.pitch_angle <= pitch;
      req_chan.speed       <= speed;
      req_chan.now_ms      <= now;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic give_target(input logic signed [ANGLE_W-1:0] yaw,
                              input logic signed [ANGLE_W-1:0] pitch,
                              input logic signed [SPEED_W-1:0] speed);
      last_yaw   = yaw;
      last_pitch = pitch;
      last_speed = speed;
      send_word(MODE_TARGET, yaw, pitch, speed, $urandom());
   endtask

   // Angle and speed fields of a poll word are don't-care, so they carry noise.
   task automatic give_poll(input logic [TIME_W-1:0] step);
      sim_ms = sim_ms + step;
      send_word(MODE_POLL, ANGLE_W'($urandom()), ANGLE_W'($urandom()),
                SPEED_W'($urandom()), sim_ms);
   endtask

   function automatic logic signed [ANGLE_W-1:0] pick_angle(
         input logic signed [ANGLE_W-1:0] prev);
      case ($urandom_range(0, 4))
         0: return ANGLE_W'($urandom());
         1: return ANGLE_W'($urandom_range(0, 40000)) - ANGLE_W'(2000);
         2: return prev + ANGLE_W'($urandom_range(0, 16)) - ANGLE_W'(8);
         3: return $urandom_range(0, 1) ? 28'sh7FFFFFF : 28'sh8000000;
         default: return ANGLE_W'($urandom_range(0, 36000));
      endcase
   endfunction

   function automatic logic signed [SPEED_W-1:0] pick_speed(
         input logic signed [SPEED_W-1:0] prev);
      case ($urandom_range(0, 3))
         0: return prev;
         1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: return SPEED_W'($urandom());
      endcase
   endfunction

   // Mostly a full walk of both motors after new targets, with stray words mixed in.
   task automatic random_burst(input int count);
      int done;
      int polls;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) < 7) begin
            give_target(pick_angle(last_yaw), pick_angle(last_pitch), pick_speed(last_speed));
            polls = $urandom_range(5, 8);
            repeat (polls) give_poll(TIME_W'(cur_interval) + $urandom_range(0, 3));
            done += polls + 1;
         end else begin
            case ($urandom_range(0, 2))
               0: begin
                  give_poll(TIME_W'($urandom_range(0, cur_interval)));
                  done++;
               end
               1: begin
                  sim_ms = $urandom();
                  give_poll('0);
                  done++;
               end
               default: begin
                  give_target(ANGLE_W'($urandom()), ANGLE_W'($urandom()),
                              SPEED_W'($urandom()));
                  done++;
               end
            endcase
         end
      end
   endtask

   // Let every expected word drain, then give the back end time to go idle.
   task automatic drain_frames();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [BYTE_W-1:0] yaw_id,
                               input logic [BYTE_W-1:0] pitch_id,
                               input logic [BYTE_W-1:0] scale,
                               input logic [BYTE_W-1:0] interval);
      write_reg(CSR_YAW_ID, yaw_id);
      write_reg(CSR_PITCH_ID, pitch_id);
      write_reg(CSR_ANGLE_SCALE, scale);
      write_reg(CSR_SEND_INTERVAL, interval);
      csr_wr_en <= 1'b0;
      cur_interval = interval;
   endtask

   initial begin : stimulus
      req_chan.valid       <= 1'b0;
      req_chan.mode        <= MODE_TARGET;
      req_chan.yaw_angle   <= '0;
      req_chan.pitch_angle <= '0;
      req_chan.speed       <= '0;
      req_chan.now_ms      <= '0;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_YAW_ID;
      csr_wr_data          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings.
      give_poll('0);                               // interval not yet reached
      give_poll(1);                                // yaw turn with nothing pending
      give_target(28'sh7FFFFFF, 28'sh8000000, 16'sh8000);
      repeat (6) give_poll(1);
      give_target(28'sh8000000, 28'sh7FFFFFF, 16'sh7FFF);
      repeat (3) give_poll(1);
      give_target(28'sd1000, 28'sd2000, 16'sh7FFF); // arrives in the middle of a walk
      repeat (4) give_poll(1);
      give_target(28'sd1004, 28'sd35995, 16'sh7FFF); // yaw moves less than the deadband
      sim_ms = 32'hFFFF_FFFE;
      repeat (5) give_poll(1);                     // time wraps through zero
      random_burst(25);
      drain_frames();

      apply_config(8'hFF, 8'h00, 8'd182, 8'd0);
      random_burst(25);
      drain_frames();

      // Both motors share one address; the head byte value is used as an id.
      apply_config(FRAME_HEAD, FRAME_HEAD, 8'd1, 8'd255);
      random_burst(20);
      drain_frames();

      // The receiver holds off while words keep coming, so the queue fills up.
      apply_config(8'h5C, 8'hA3, 8'd0, 8'd3);
      calm = 1'b1;
      hold_rsp = 1'b1;
      random_burst(20);
      calm = 1'b0;
      drain_frames();

      apply_config(BYTE_W'($urandom()), BYTE_W'($urandom()), 8'd255, 8'd17);
      random_burst(25);
      drain_frames();

      apply_config(BYTE_W'($urandom()), BYTE_W'($urandom()),
                   BYTE_W'($urandom_range(1, 182)), BYTE_W'($urandom_range(0, 20)));
      random_burst(20);
      drain_frames();

      if (fail_count == 0 && words_due == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
